### design/qsosc_pkg.sv
// Shared constants for the quadrature sine oscillator.
package qsosc_pkg;

  // Default sizes handed to the top level.
  localparam int CHANNELS_DEF        = 64;
  localparam int PHASE_BITS_DEF      = 32;
  localparam int SINE_TABLE_BITS_DEF = 15;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 19;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINE_METHOD = 1'd1;
  localparam logic [CFG_DATA_W-1:0] RATE_RESET = 19'd48000;

  // Stream payload widths.
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;

  // Fade limits, in units of 1/2560 Hz.
  localparam logic [29:0] FADE_START_CAP = 30'd51200000;
  localparam logic [29:0] FADE_DEN_MIN   = 30'd2560;

  // Odd quarter-wave polynomial, Q30 coefficients, lowest order first.
  localparam logic signed [31:0] POLY_COEF [5] = '{
    32'sd1686629713, -32'sd693598668, 32'sd85569306, -32'sd5026995, 32'sd172272
  };

endpackage

### design/qsosc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qsosc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### design/qsosc_mul.sv
// Unsigned 32 by 32 multiplier with a registered product.
module qsosc_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk_i) begin
    p_o <= 64'(a_i) * 64'(b_i);
  end

endmodule

### design/qsosc_div.sv
// Restoring divider that produces one quotient bit per cycle.
module qsosc_div #(
  parameter int DVD_W = 56,
  parameter int REM_W = 19,
  parameter int QUO_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [REM_W-1:0] rem_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [REM_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [QUO_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] dvd_q;
  logic [REM_W-1:0] dvs_q;
  logic [QUO_W-1:0] quot_q;
  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             fits;

  // Shift in the next dividend bit and try to subtract the divisor.
  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = trial >= {1'b0, dvs_q};
    rem_d = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
  end

  // Iteration count and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DVD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Remainder, dividend and quotient shift registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_i;
      dvd_q  <= dividend_i;
      dvs_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      dvd_q  <= dvd_q << 1;
      quot_q <= {quot_q[QUO_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

### design/quadrature_sine_oscillator_top.sv
// Top level: per-channel phase memory, sequencer, and sine/cosine datapath.
//
//  Channel  | Direction | Transfer contents
//  s_axis   | in        | tuser: req_type; tdata: channel, frequency, amplitude, phase_offset
//  m_axis   | out       | tdata: out_channel, sine_out, cosine_out
//  cfg      | in        | one register write per cycle with cfg_we_i high
//
// A sample request presents its result once the phase step divider, which resolves one
// quotient bit per cycle, has finished; the next request is taken in the following cycle
// at the earliest. A phase reset request zeroes its channel's phase in the read state.
// One request is worked on at a time. After reset a clearing pass zeroes the phase
// memory, and no request is taken until it ends. A result waits in the output register
// while the next request is already taken; a request only stalls at its end if it is
// still there.
module quadrature_sine_oscillator_top #(
  parameter int CHANNELS        = qsosc_pkg::CHANNELS_DEF,
  parameter int PHASE_BITS      = qsosc_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = qsosc_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Sample requests.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [5:0] channel, [37:6] frequency, [53:38] amplitude, [69:54] phase_offset
  input  logic [qsosc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [0] req_type
  input  logic                                s_axis_tuser,
  // Samples.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [5:0] out_channel, [21:6] sine_out, [37:22] cosine_out
  output logic [qsosc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // Configuration writes.
  input  logic                                cfg_we_i,
  input  logic [qsosc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [qsosc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  import qsosc_pkg::*;

  localparam int PB     = PHASE_BITS;
  localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int STEP_W = PB + 24;
  localparam logic [29:0] TBL_MASK = ~((30'd1 << (31 - SINE_TABLE_BITS)) - 30'd1);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_FADE, ST_FDIV, ST_GSQ, ST_GS, ST_GG,
    ST_LEVEL, ST_LVLW, ST_POLX, ST_POLX2, ST_POLM, ST_POLA, ST_POLV, ST_POLS,
    ST_SCL, ST_SCR, ST_FIN
  } st_e;

  st_e state_q, state_d;

  // Control registers.
  logic [AW-1:0]         clr_q, clr_d;
  logic                  out_valid_q, out_valid_d;
  logic [CFG_DATA_W-1:0] rate_q;
  logic                  method_q;

  // Payload registers.
  logic                  req_q, req_d;
  logic [5:0]            ch_q, ch_d;
  logic                  fneg_q, fneg_d;
  logic [31:0]           af_q, af_d;
  logic [15:0]           amp_q, amp_d;
  logic [15:0]           off_q, off_d;
  logic [PB-1:0]         old_q, old_d;
  logic [31:0]           t_q, t_d;
  logic [35:0]           f_q, f_d;
  logic [29:0]           start_q, start_d;
  logic [29:0]           nyq_q, nyq_d;
  logic [15:0]           p_q, p_d;
  logic [16:0]           gain_q, gain_d;
  logic [31:0]           level_q, level_d;
  logic                  ang_q, ang_d;
  logic [30:0]           x_d;
  logic [30:0]           x2_q, x2_d;
  logic signed [33:0]    acc_q, acc_d;
  logic [1:0]            k_q, k_d;
  logic [31:0]           vmag_q, vmag_d;
  logic                  vneg_q, vneg_d;
  logic [15:0]           sin_q, sin_d;
  logic [15:0]           cos_q, cos_d;
  logic [5:0]            o_ch_q, o_ch_d;
  logic [15:0]           o_sin_q, o_sin_d;
  logic [15:0]           o_cos_q, o_cos_d;

  // Memory, multiplier and divider connections.
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [PB-1:0]         ram_wdata, ram_rdata;
  logic [31:0]           mul_a, mul_b;
  logic [63:0]           prod;
  logic                  fdiv_start, fdiv_busy;
  logic [15:0]           fdiv_quot;
  logic [29:0]           fdiv_rem, fdiv_den;
  logic                  sdiv_start, sdiv_busy;
  logic [PB-1:0]         sdiv_quot;

  // Combinational helpers.
  logic [5:0]            in_ch;
  logic [31:0]           in_fr;
  logic [CFG_DATA_W-1:0] rate_eff;
  logic [PB-1:0]         ph;
  logic [PB+31:0]        ph_wide;
  logic [29:0]           start_raw;
  logic [31:0]           ang;
  logic [29:0]           ang_r;
  logic [32:0]           term_mag;
  logic signed [33:0]    term;
  logic [33:0]           acc_mag;
  logic [17:0]           fade_s;
  logic [64:0]           rnd;
  logic [19:0]           q;
  logic [15:0]           res;
  logic                  out_free;

  qsosc_ram #(
    .WIDTH (PB),
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_phase_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  qsosc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Fade progress: (f - start) * 2^16 / den.
  qsosc_div #(
    .DVD_W (16),
    .REM_W (30),
    .QUO_W (16)
  ) u_fade_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (fdiv_start),
    .rem_i      (fdiv_rem),
    .dividend_i (16'd0),
    .divisor_i  (fdiv_den),
    .busy_o     (fdiv_busy),
    .quot_o     (fdiv_quot)
  );

  // Phase step: |frequency| * 2^(PHASE_BITS-8) / rate.
  qsosc_div #(
    .DVD_W (STEP_W),
    .REM_W (CFG_DATA_W),
    .QUO_W (PB)
  ) u_step_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sdiv_start),
    .rem_i      ('0),
    .dividend_i ({af_q, {(PB - 8){1'b0}}}),
    .divisor_i  (rate_eff),
    .busy_o     (sdiv_busy),
    .quot_o     (sdiv_quot)
  );

  assign in_ch    = s_axis_tdata[5:0];
  assign in_fr    = s_axis_tdata[37:6];
  assign rate_eff = (rate_q == '0) ? CFG_DATA_W'(1) : rate_q;
  assign out_free = !out_valid_q || m_axis_tready;

  // Sample angle from the stored phase and offset; raw fade start from the rate.
  always_comb begin
    ph        = ram_rdata + (PB'(off_q) << (PB - 16));
    ph_wide   = {ph, 32'd0};
    start_raw = (30'(rate_eff) << 10) + (30'(rate_eff) << 7);
  end

  // Quarter-wave position of the current angle; the table method drops low bits.
  always_comb begin
    ang   = ang_q ? (t_q + 32'h4000_0000) : t_q;
    ang_r = method_q ? (ang[29:0] & TBL_MASK) : ang[29:0];
    x_d   = ang[30] ? (31'h4000_0000 - {1'b0, ang_r}) : {1'b0, ang_r};
  end

  // Product terms of the polynomial, the fade smoothstep and the output scaling.
  always_comb begin
    term_mag = prod[62:30];
    term     = acc_q[33] ? -$signed({1'b0, term_mag}) : $signed({1'b0, term_mag});
    acc_mag  = acc_q[33] ? 34'(-acc_q) : 34'(acc_q);
    fade_s   = prod[33:16];
    rnd      = 65'(prod) + (65'd1 << 44);
    q        = rnd[64:45];
    if (vneg_q) begin
      res = (q > 20'd32768) ? 16'h8000 : 16'(-q);
    end else begin
      res = (q > 20'd32767) ? 16'h7FFF : q[15:0];
    end
  end

  // Sequencer and datapath next values.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    req_d       = req_q;
    ch_d        = ch_q;
    fneg_d      = fneg_q;
    af_d        = af_q;
    amp_d       = amp_q;
    off_d       = off_q;
    old_d       = old_q;
    t_d         = t_q;
    f_d         = f_q;
    start_d     = start_q;
    nyq_d       = nyq_q;
    p_d         = p_q;
    gain_d      = gain_q;
    level_d     = level_q;
    ang_d       = ang_q;
    x2_d        = x2_q;
    acc_d       = acc_q;
    k_d         = k_q;
    vmag_d      = vmag_q;
    vneg_d      = vneg_q;
    sin_d       = sin_q;
    cos_d       = cos_q;
    o_ch_d      = o_ch_q;
    o_sin_d     = o_sin_q;
    o_cos_d     = o_cos_q;
    ram_we      = 1'b0;
    ram_waddr   = AW'(ch_q);
    ram_wdata   = '0;
    ram_raddr   = AW'(in_ch);
    mul_a       = '0;
    mul_b       = '0;
    fdiv_start  = 1'b0;
    fdiv_rem    = 30'(f_q) - start_q;
    fdiv_den    = ((nyq_q - start_q) < FADE_DEN_MIN) ? FADE_DEN_MIN : (nyq_q - start_q);
    sdiv_start  = 1'b0;
    s_axis_tready = (state_q == ST_IDLE);

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      // Zero the phase memory one entry per cycle.
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(CHANNELS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      // Take a request and read its channel's phase.
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          req_d  = s_axis_tuser;
          ch_d   = in_ch;
          fneg_d = in_fr[31];
          af_d   = in_fr[31] ? (32'd0 - in_fr) : in_fr;
          amp_d  = s_axis_tdata[53:38];
          off_d  = s_axis_tdata[69:54];
          if (int'(in_ch) < CHANNELS) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (req_q) begin
          ram_we  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          sdiv_start = 1'b1;
          old_d   = ram_rdata;
          t_d     = ph_wide[PB+31 -: 32];
          f_d     = (36'(af_q) << 3) + (36'(af_q) << 1);
          start_d = (start_raw > FADE_START_CAP) ? FADE_START_CAP : start_raw;
          nyq_d   = (30'(rate_eff) << 10) + (30'(rate_eff) << 8);
          state_d = ST_FADE;
        end
      end
      // Fade gain: full, none, or one minus smoothstep of the progress.
      ST_FADE: begin
        if (f_q <= 36'(start_q)) begin
          gain_d  = 17'h1_0000;
          state_d = ST_LEVEL;
        end else if (f_q >= 36'(nyq_q)) begin
          gain_d  = '0;
          state_d = ST_LEVEL;
        end else begin
          fdiv_start = 1'b1;
          state_d    = ST_FDIV;
        end
      end
      ST_FDIV: begin
        if (!fdiv_busy) begin
          p_d     = fdiv_quot;
          state_d = ST_GSQ;
        end
      end
      ST_GSQ: begin
        mul_a   = 32'(p_q);
        mul_b   = 32'(p_q);
        state_d = ST_GS;
      end
      ST_GS: begin
        mul_a   = 32'(prod[31:16]);
        mul_b   = 32'(18'd196608 - {1'b0, p_q, 1'b0});
        state_d = ST_GG;
      end
      ST_GG: begin
        gain_d  = 17'(18'h1_0000 - fade_s);
        state_d = ST_LEVEL;
      end
      ST_LEVEL: begin
        mul_a   = 32'(amp_q);
        mul_b   = 32'(gain_q);
        state_d = ST_LVLW;
      end
      ST_LVLW: begin
        level_d = prod[31:0];
        ang_d   = 1'b0;
        state_d = ST_POLX;
      end
      // Odd polynomial in Horner form over x squared.
      ST_POLX: begin
        mul_a   = 32'(x_d);
        mul_b   = 32'(x_d);
        state_d = ST_POLX2;
      end
      ST_POLX2: begin
        x2_d    = prod[60:30];
        acc_d   = 34'(POLY_COEF[4]);
        k_d     = 2'd3;
        state_d = ST_POLM;
      end
      ST_POLM: begin
        mul_a   = acc_mag[31:0];
        mul_b   = 32'(x2_q);
        state_d = ST_POLA;
      end
      ST_POLA: begin
        acc_d = 34'(POLY_COEF[k_q]) + term;
        if (k_q == 2'd0) begin
          state_d = ST_POLV;
        end else begin
          k_d     = k_q - 1'b1;
          state_d = ST_POLM;
        end
      end
      ST_POLV: begin
        mul_a   = acc_mag[31:0];
        mul_b   = 32'(x_d);
        state_d = ST_POLS;
      end
      ST_POLS: begin
        vmag_d  = prod[61:30];
        vneg_d  = acc_q[33] ^ ang[31];
        state_d = ST_SCL;
      end
      // Scale by the level, round half away from zero, saturate.
      ST_SCL: begin
        mul_a   = vmag_q;
        mul_b   = level_q;
        state_d = ST_SCR;
      end
      ST_SCR: begin
        if (!ang_q) begin
          sin_d   = res;
          ang_d   = 1'b1;
          state_d = ST_POLX;
        end else begin
          cos_d   = res;
          state_d = ST_FIN;
        end
      end
      // Write back the advanced phase and hand over the result.
      ST_FIN: begin
        if (!sdiv_busy && out_free) begin
          ram_we      = 1'b1;
          ram_wdata   = fneg_q ? (old_q - sdiv_quot) : (old_q + sdiv_quot);
          out_valid_d = 1'b1;
          o_ch_d      = ch_q;
          o_sin_d     = sin_q;
          o_cos_d     = cos_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      rate_q      <= RATE_RESET;
      method_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SAMPLE_RATE: rate_q   <= cfg_data_i;
          CFG_SINE_METHOD: method_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    ch_q    <= ch_d;
    fneg_q  <= fneg_d;
    af_q    <= af_d;
    amp_q   <= amp_d;
    off_q   <= off_d;
    old_q   <= old_d;
    t_q     <= t_d;
    f_q     <= f_d;
    start_q <= start_d;
    nyq_q   <= nyq_d;
    p_q     <= p_d;
    gain_q  <= gain_d;
    level_q <= level_d;
    ang_q   <= ang_d;
    x2_q    <= x2_d;
    acc_q   <= acc_d;
    k_q     <= k_d;
    vmag_q  <= vmag_d;
    vneg_q  <= vneg_d;
    sin_q   <= sin_d;
    cos_q   <= cos_d;
    o_ch_q  <= o_ch_d;
    o_sin_q <= o_sin_d;
    o_cos_q <= o_cos_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, o_cos_q, o_sin_q, o_ch_q};

endmodule

### sim/tb_quadrature_sine_oscillator_top.sv
// Self-checking testbench for the quadrature sine oscillator top level.
`timescale 1ns / 1ps

module tb_quadrature_sine_oscillator_top;
  import qsosc_pkg::*;

  localparam int NCH = 64;
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_RESET  = 1'b1;

  // Laid out like the sample transfer, lowest field last.
  typedef struct packed {
    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;
    logic [5:0]         ch;
  } sample_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Predictor state and the queue of samples still owed by the block.
  logic [31:0] osc_phase [NCH];
  logic [18:0] rate_reg;
  logic        table_mode;
  sample_t     owed_samples [$];
  int          mismatches = 0;
  int          rx_hold = 0;

  always #5 clk_i = ~clk_i;

  quadrature_sine_oscillator_top u_top (.*);

  // Q30 product, truncated toward zero.
  function automatic longint q30_mul(longint a, longint b);
    longint unsigned ma, mb, p;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p = (ma * mb) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint quarter_sine(longint x);
    longint x2, acc;
    x2 = q30_mul(x, x);
    acc = POLY_COEF[4];
    for (int k = 3; k >= 0; k--) acc = longint'(POLY_COEF[k]) + q30_mul(acc, x2);
    return q30_mul(acc, x);
  endfunction

  function automatic longint turn_sine(logic [31:0] t, logic tab);
    longint x, v;
    logic [14:0] idx;
    if (tab) begin
      idx = t[30:16];
      if (!idx[14]) x = longint'(idx) << 16;
      else x = (longint'(1) << 30) - (longint'(idx[13:0]) << 16);
    end else begin
      x = t[30] ? (longint'(1) << 30) - longint'(t[29:0]) : longint'(t[29:0]);
    end
    v = quarter_sine(x);
    return t[31] ? -v : v;
  endfunction

  function automatic longint unsigned fade_q16(longint unsigned af, longint unsigned rate);
    longint unsigned f, st, nyq, den, p, p2, s;
    f = af * 10;
    st = rate * 1152;
    nyq = rate * 1280;
    if (st > 51200000) st = 51200000;
    if (f <= st) return 65536;
    if (f >= nyq) return 0;
    den = nyq - st;
    if (den < 2560) den = 2560;
    p = ((f - st) << 16) / den;
    if (p > 65536) p = 65536;
    p2 = (p * p) >> 16;
    s = (p2 * (196608 - 2 * p)) >> 16;
    return 65536 - s;
  endfunction

  function automatic logic [15:0] to_q15(longint sv, longint unsigned level);
    longint unsigned m, q;
    m = sv < 0 ? -sv : sv;
    q = (m * level + (longint'(1) << 44)) >> 45;
    if (sv < 0) begin
      if (q > 32768) q = 32768;
      return 16'(-q);
    end
    if (q > 32767) q = 32767;
    return 16'(q);
  endfunction

  // Works out the sample for one accepted sample request and advances the phase; a reset request zeroes the phase.
  task automatic predict_sample(logic rq, logic [5:0] ch, logic [31:0] fr,
                                logic [15:0] amp, logic [15:0] off);
    longint unsigned rate, af, level, step;
    logic [31:0] t;
    sample_t s;
    rate = rate_reg == 0 ? 1 : rate_reg;
    if (rq == REQ_RESET) begin
      osc_phase[ch] = '0;
      return;
    end
    af = fr[31] ? 64'h1_0000_0000 - fr : fr;
    t = osc_phase[ch] + {off, 16'h0};
    level = amp * fade_q16(af, rate);
    s.ch = ch;
    s.sin_v = to_q15(turn_sine(t, table_mode), level);
    s.cos_v = to_q15(turn_sine(t + 32'h4000_0000, table_mode), level);
    owed_samples.push_back(s);
    step = ((af / rate) << 24) + (((af % rate) << 24) / rate);
    if (fr[31]) osc_phase[ch] = osc_phase[ch] - 32'(step);
    else osc_phase[ch] = osc_phase[ch] + 32'(step);
  endtask

  // Offers one request, with an occasional random gap when gaps is set, then records it on its transfer.
  // The valid stays up after a transfer so that the next request can follow at once.
  task automatic send_req(logic rq, logic [5:0] ch, logic [31:0] fr,
                          logic [15:0] amp, logic [15:0] off, bit gaps = 1);
    if (gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rq;
    s_axis_tdata  <= {2'b00, off, amp, fr, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_sample(rq, ch, fr, amp, off);
  endtask

  // Stops offering requests, then waits for every owed sample plus the block's latency.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (owed_samples.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SAMPLE_RATE) rate_reg = val;
    else table_mode = val[0];
  endtask

  function automatic logic [31:0] rand_freq();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($urandom_range(0, 30000) << 8);
      2: return -32'($urandom_range(0, 30000) << 8);
      3: return 32'($urandom_range(4500000, 6200000));
      default: return 32'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_burst(int n, bit gaps = 1);
    for (int i = 0; i < n; i++) begin
      send_req($urandom_range(0, 9) == 0 ? REQ_RESET : REQ_SAMPLE,
               6'($urandom), rand_freq(), 16'($urandom), 16'($urandom), gaps);
    end
  endtask

  // Field extremes, both request kinds, both sine methods.
  task automatic test_directed();
    send_req(REQ_SAMPLE, 6'd0, 32'd0, 16'hFFFF, 16'd0);
    send_req(REQ_SAMPLE, 6'd63, 32'h7FFF_FFFF, 16'd16384, 16'hFFFF);
    send_req(REQ_SAMPLE, 6'd63, 32'h8000_0000, 16'd16384, 16'h4000);
    send_req(REQ_SAMPLE, 6'd1, 32'd256000, 16'd16384, 16'h8000);
    send_req(REQ_SAMPLE, 6'd1, -32'sd256000, 16'd0, 16'hC000);
    send_req(REQ_SAMPLE, 6'd2, 32'd5600000, 16'd16384, 16'h2000);
    send_req(REQ_SAMPLE, 6'd2, 32'd6000000, 16'hFFFF, 16'h6000);
    send_req(REQ_SAMPLE, 6'd3, 32'd5500000, 16'd32768, 16'h1000);
    send_req(REQ_RESET,  6'd1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_req(REQ_SAMPLE, 6'd1, 32'd1, 16'd16384, 16'd0);
    write_reg(CFG_SINE_METHOD, 19'd1);
    send_req(REQ_SAMPLE, 6'd4, 32'd1000 << 8, 16'd16384, 16'h4000);
    send_req(REQ_SAMPLE, 6'd4, 32'd1000 << 8, 16'hFFFF, 16'hFFFF);
    send_req(REQ_SAMPLE, 6'd5, 32'd0, 16'd16384, 16'h8000);
  endtask

  // Extreme and unusual sample rates, including zero, with random traffic.
  task automatic test_rates();
    logic [18:0] rates [6] = '{19'd0, 19'd1, 19'h7FFFF, 19'd384000, 19'd8000, 19'd44100};
    foreach (rates[r]) begin
      write_reg(CFG_SAMPLE_RATE, rates[r]);
      write_reg(CFG_SINE_METHOD, 19'($urandom_range(0, 1)));
      random_burst(150);
    end
    write_reg(CFG_SAMPLE_RATE, RATE_RESET);
  endtask

  // Long receiver hold while the sender keeps offering requests.
  task automatic test_backpressure();
    rx_hold = 600;
    random_burst(40, 0);
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_SINE_METHOD, 19'(ph & 1));
      random_burst(250, ph < 2);
    end
  endtask

  // Receiver: stall pattern with quiet stretches and an optional long hold.
  initial begin
    int cnt;
    cnt = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      cnt++;
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if ((cnt / 500) % 2 == 0) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  // Compares each sample transfer with the oldest owed sample.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sample_t got, exp_s;
      got = m_axis_tdata[37:0];
      if (owed_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected sample transfer: %p", got);
      end else begin
        exp_s = owed_samples.pop_front();
        if (got !== exp_s) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Sample mismatch: expected ch %0d sin %0d cos %0d, got ch %0d sin %0d cos %0d",
                     exp_s.ch, exp_s.sin_v, exp_s.cos_v, got.ch, got.sin_v, got.cos_v);
        end
      end
    end
  end

  initial begin
    for (int c = 0; c < NCH; c++) osc_phase[c] = '0;
    rate_reg = RATE_RESET;
    table_mode = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_rates();
    test_backpressure();
    test_random();
    drain();
    if (mismatches == 0 && owed_samples.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
design/qsosc_pkg.sv
design/qsosc_ram.sv
design/qsosc_mul.sv
design/qsosc_div.sv
design/quadrature_sine_oscillator_top.sv
sim/tb_quadrature_sine_oscillator_top.sv
